FILE: rtl/core/int64_divide_modulo_macros.svh
// ----------------------------------------------------------------------------
// int64_divide_modulo assertion macros
// Concurrent assertion helpers for the divider RTL, used by the division cell.
// ----------------------------------------------------------------------------
`ifndef INT64_DIVIDE_MODULO_MACROS_SVH
`define INT64_DIVIDE_MODULO_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define IDM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("int64_divide_modulo: assertion failed");

// Next-cycle implication, disabled during reset
`define IDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("int64_divide_modulo: assertion failed");

`else

`define IDM_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define IDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/idm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idm_pkg
// Shared types and constants for the pipelined integer divider.
// ----------------------------------------------------------------------------
package idm_pkg;

    // Fixed field widths on the stream ports
    localparam int FIELD_W = 64;
    localparam int MODE_W  = 2;

    // Operation codes carried in the request tuser
    localparam logic [MODE_W-1:0] MODE_UQUOT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UREM  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SQUOT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SREM  = 2'd3;

    // Per-request control that rides along the cell chain
    typedef struct packed {
        logic rem_sel;  // deliver remainder instead of quotient
        logic neg;      // negate the selected magnitude at the end
        logic dz;       // divisor was zero
    } ctl_t;

endpackage

FILE: rtl/core/int64_divide_modulo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int64_divide_modulo
// Pipelined signed/unsigned divide and modulo, one quotient bit per cell.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: tdata carries dividend and divisor,
//   tuser the mode (unsigned quotient, unsigned remainder, signed quotient,
//   signed remainder). Results leave on m_axis: tdata is the quotient or
//   remainder, tuser flags a zero divisor.
//   From acceptance to m_axis_tvalid a request passes through the entry
//   cell, which registers it at the accepting edge, then DATA_WIDTH division
//   cells and one exit cell.
//   Throughput is one request per cycle while the receiver keeps up; every
//   cell in the chain is a register stage holding one request in flight.
//   Each cell is ready when empty or when its successor takes its request,
//   so bubbles are squeezed out and requests keep entering while a result
//   waits at the output.
//   When the receiver stalls, requests pile up cell by cell; s_axis_tready
//   drops only once the whole chain is full.
//   Reset clears all valid bits; the chain is empty and ready right after.
//   Zero divisor: magnitude quotient all ones, remainder the dividend.
// ----------------------------------------------------------------------------
module int64_divide_modulo #(
    parameter int DATA_WIDTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,   // [63:0] dividend, [127:64] divisor
    input  logic [1:0]    s_axis_tuser,   // [1:0] mode
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [63:0]   m_axis_tdata,   // [63:0] result
    output logic [0:0]    m_axis_tuser    // [0] div_by_zero
);

    localparam int W = DATA_WIDTH;

    // Inter-cell links, index k feeds division cell k
    logic            lnk_valid [0:W];
    logic            lnk_ready [0:W];
    logic [W-1:0]    lnk_r     [0:W];
    logic [W-1:0]    lnk_nq    [0:W];
    logic [W-1:0]    lnk_den   [0:W];
    idm_pkg::ctl_t   lnk_ctl   [0:W];

    // Entry cell
    idm_prep_cell #(
        .W (W)
    ) u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_mode     (s_axis_tuser),
        .in_dividend (s_axis_tdata[63:0]),
        .in_divisor  (s_axis_tdata[127:64]),
        .out_valid   (lnk_valid[0]),
        .out_ready   (lnk_ready[0]),
        .out_r       (lnk_r[0]),
        .out_nq      (lnk_nq[0]),
        .out_den     (lnk_den[0]),
        .out_ctl     (lnk_ctl[0])
    );

    // Division cell chain, one quotient bit per cell
    for (genvar k = 0; k < W; k++)
    begin : g_cell
        idm_div_cell #(
            .W (W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (lnk_valid[k]),
            .in_ready  (lnk_ready[k]),
            .in_r      (lnk_r[k]),
            .in_nq     (lnk_nq[k]),
            .in_den    (lnk_den[k]),
            .in_ctl    (lnk_ctl[k]),
            .out_valid (lnk_valid[k+1]),
            .out_ready (lnk_ready[k+1]),
            .out_r     (lnk_r[k+1]),
            .out_nq    (lnk_nq[k+1]),
            .out_den   (lnk_den[k+1]),
            .out_ctl   (lnk_ctl[k+1])
        );
    end

    // Exit cell; the final divisor copy is not needed past the chain
    idm_finish_cell #(
        .W (W)
    ) u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (lnk_valid[W]),
        .in_ready   (lnk_ready[W]),
        .in_r       (lnk_r[W]),
        .in_q       (lnk_nq[W]),
        .in_ctl     (lnk_ctl[W]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (m_axis_tdata),
        .out_dz     (m_axis_tuser[0])
    );

endmodule

FILE: rtl/core/idm_prep_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idm_prep_cell
// Entry stage: masks operands, takes magnitudes and sets up sign control.
// ----------------------------------------------------------------------------
module idm_prep_cell #(
    parameter int W = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [idm_pkg::MODE_W-1:0]    in_mode,
    input  logic [idm_pkg::FIELD_W-1:0]   in_dividend,
    input  logic [idm_pkg::FIELD_W-1:0]   in_divisor,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [W-1:0]                  out_r,
    output logic [W-1:0]                  out_nq,
    output logic [W-1:0]                  out_den,
    output idm_pkg::ctl_t                 out_ctl
);

    logic            valid_reg;
    logic [W-1:0]    nq_reg, nq_next;
    logic [W-1:0]    den_reg, den_next;
    idm_pkg::ctl_t   ctl_reg, ctl_next;

    logic [W-1:0]    a;
    logic [W-1:0]    b;
    logic            an;
    logic            bn;
    logic            is_signed;

    assign in_ready = !valid_reg || out_ready;

    // Operand magnitudes and sign control
    always_comb
    begin
        a         = in_dividend[W-1:0];
        b         = in_divisor[W-1:0];
        an        = a[W-1];
        bn        = b[W-1];
        is_signed = 1'b0;
        ctl_next  = '0;
        unique case (in_mode)
            idm_pkg::MODE_UQUOT:
            begin
                ctl_next.rem_sel = 1'b0;
            end
            idm_pkg::MODE_UREM:
            begin
                ctl_next.rem_sel = 1'b1;
            end
            idm_pkg::MODE_SQUOT:
            begin
                is_signed        = 1'b1;
                ctl_next.rem_sel = 1'b0;
                ctl_next.neg     = an ^ bn;
            end
            idm_pkg::MODE_SREM:
            begin
                is_signed        = 1'b1;
                ctl_next.rem_sel = 1'b1;
                ctl_next.neg     = an;
            end
            default:
            begin
                ctl_next = '0;
            end
        endcase
        ctl_next.dz = (b == '0);
        nq_next     = (is_signed && an) ? ('0 - a) : a;
        den_next    = (is_signed && bn) ? ('0 - b) : b;
    end

    // Control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            nq_reg  <= nq_next;
            den_reg <= den_next;
            ctl_reg <= ctl_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_r     = '0;
    assign out_nq    = nq_reg;
    assign out_den   = den_reg;
    assign out_ctl   = ctl_reg;

endmodule

FILE: rtl/core/idm_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idm_div_cell
// One restoring division step: shift in a dividend bit, trial subtract.
// ----------------------------------------------------------------------------
`include "int64_divide_modulo_macros.svh"

module idm_div_cell #(
    parameter int W = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [W-1:0]   in_r,
    input  logic [W-1:0]   in_nq,
    input  logic [W-1:0]   in_den,
    input  idm_pkg::ctl_t  in_ctl,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [W-1:0]   out_r,
    output logic [W-1:0]   out_nq,
    output logic [W-1:0]   out_den,
    output idm_pkg::ctl_t  out_ctl
);

    logic            valid_reg;
    logic [W-1:0]    r_reg, r_next;
    logic [W-1:0]    nq_reg, nq_next;
    logic [W-1:0]    den_reg;
    idm_pkg::ctl_t   ctl_reg;

    logic [W:0]      shifted;
    logic [W+1:0]    diff;
    logic            qbit;

    assign in_ready = !valid_reg || out_ready;

    // Trial subtract on the partial remainder with its carry bit
    always_comb
    begin
        shifted = {in_r, in_nq[W-1]};
        diff    = {1'b0, shifted} - {2'b00, in_den};
        qbit    = ~diff[W+1];
        r_next  = qbit ? diff[W-1:0] : shifted[W-1:0];
        nq_next = {in_nq[W-2:0], qbit};
    end

    // Control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            r_reg   <= r_next;
            nq_reg  <= nq_next;
            den_reg <= in_den;
            ctl_reg <= in_ctl;
        end
    end

    assign out_valid = valid_reg;
    assign out_r     = r_reg;
    assign out_nq    = nq_reg;
    assign out_den   = den_reg;
    assign out_ctl   = ctl_reg;

    // Partial remainder stays below a nonzero divisor
    `IDM_ASSERT_NOW(a_rem_below_den, clk, rst_n, valid_reg && (den_reg != '0), r_reg < den_reg)
    // Zero-divisor flag agrees with the carried divisor
    `IDM_ASSERT_NOW(a_dz_matches, clk, rst_n, valid_reg, ctl_reg.dz == (den_reg == '0))
    // A stalled cell keeps its partial result
    `IDM_ASSERT_NEXT(a_stall_hold, clk, rst_n, valid_reg && !out_ready,
                     valid_reg && $stable(r_reg) && $stable(nq_reg))

endmodule

FILE: rtl/core/idm_finish_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idm_finish_cell
// Exit stage: selects quotient or remainder, applies sign, holds result.
// ----------------------------------------------------------------------------
module idm_finish_cell #(
    parameter int W = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [W-1:0]                  in_r,
    input  logic [W-1:0]                  in_q,
    input  idm_pkg::ctl_t                 in_ctl,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [idm_pkg::FIELD_W-1:0]   out_result,
    output logic                          out_dz
);

    logic                          valid_reg;
    logic [idm_pkg::FIELD_W-1:0]   result_reg, result_next;
    logic                          dz_reg;
    logic [W-1:0]                  sel;
    logic [W-1:0]                  res;

    assign in_ready = !valid_reg || out_ready;

    // Select and re-sign
    always_comb
    begin
        sel         = in_ctl.rem_sel ? in_r : in_q;
        res         = in_ctl.neg ? ('0 - sel) : sel;
        result_next = idm_pkg::FIELD_W'(res);
    end

    // Control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            result_reg <= result_next;
            dz_reg     <= in_ctl.dz;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;
    assign out_dz     = dz_reg;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the pipelined divide/modulo unit. Each accepted
// request is run through a bit-serial restoring divider kept here. The
// result goes into a queue, and every delivered result is checked in order
// against the oldest entry. Directed corner operands come first, then
// random operands of mixed magnitudes. The sender works in bursts and the
// receiver stalls in changing patterns, with one long hold-off that fills
// the whole chain.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          MODE_W       = idm_pkg::MODE_W;
    localparam int          CLK_HALF     = 4;
    localparam int          RAND_ITEMS   = 1400;
    localparam int          FILL_ITEMS   = 150;
    localparam int          HOLD_CYCLES  = 250;
    localparam int          DRAIN_CYCLES = 80;
    localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MOST_NEG     = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MOST_POS     = 64'h7FFF_FFFF_FFFF_FFFF;

    // Expected outcome of one request
    typedef struct {
        logic [63:0] value;
        logic        dz;
    } div_outcome_t;

    // ------------------------------------------------------------------------
    // Divide predictor and in-order result queue
    // ------------------------------------------------------------------------
    class div_ledger;
        div_outcome_t pending[$];
        int           failures = 0;

        // Restoring division, one quotient bit per step, carry bit kept
        function automatic void long_div(input logic [63:0] num, input logic [63:0] den,
                                         output logic [63:0] quo, output logic [63:0] rem);
            logic carry;
            quo = '0;
            rem = '0;
            for (int i = 63; i >= 0; i--)
            begin
                carry = rem[63];
                rem   = {rem[62:0], num[i]};
                if (carry || rem >= den)
                begin
                    rem    = rem - den;
                    quo[i] = 1'b1;
                end
            end
        endfunction

        function automatic div_outcome_t divide_rem(logic [MODE_W-1:0] mode,
                                                    logic [63:0] a, logic [63:0] b);
            div_outcome_t out;
            logic [63:0]  mag_a;
            logic [63:0]  mag_b;
            logic [63:0]  quo;
            logic [63:0]  rem;
            // signed modes work on magnitudes, then fix the sign
            mag_a = (mode[1] && a[63]) ? -a : a;
            mag_b = (mode[1] && b[63]) ? -b : b;
            long_div(mag_a, mag_b, quo, rem);
            case (mode)
                idm_pkg::MODE_UQUOT: out.value = quo;
                idm_pkg::MODE_UREM:  out.value = rem;
                idm_pkg::MODE_SQUOT: out.value = (a[63] != b[63]) ? -quo : quo;
                default:             out.value = a[63] ? -rem : rem;
            endcase
            out.dz = (b == '0);
            return out;
        endfunction

        function void note_request(logic [MODE_W-1:0] mode, logic [63:0] a, logic [63:0] b);
            pending.push_back(divide_rem(mode, a, b));
        endfunction

        function int outstanding();
            return pending.size();
        endfunction

        function void flag_failure(string what, logic [63:0] want, logic [63:0] got);
            failures++;
            if (failures <= 10)
                $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
        endfunction

        function void check_result(logic [63:0] value, logic dz);
            div_outcome_t want;
            if (pending.size() == 0)
            begin
                flag_failure("result with no request outstanding", '0, value);
                return;
            end
            want = pending.pop_front();
            if (value !== want.value)
                flag_failure("result", want.value, value);
            if (dz !== want.dz)
                flag_failure("div_by_zero", 64'(want.dz), 64'(dz));
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [127:0]        s_axis_tdata = '0;
    logic [MODE_W-1:0]   s_axis_tuser = idm_pkg::MODE_UQUOT;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [63:0]         m_axis_tdata;
    logic [0:0]          m_axis_tuser;

    // set by the sender to ask for the long receiver hold-off
    logic                hold_off_req = 1'b0;

    div_ledger           ledger = new();

    int64_divide_modulo dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    always #CLK_HALF clk = ~clk;

    // Watchdog
    initial
    begin
        #5ms;
        $display("int64_divide_modulo: mismatch");
        $finish;
    end

    // Handshake monitor: requests feed the predictor, results are checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                ledger.note_request(s_axis_tuser, s_axis_tdata[63:0], s_axis_tdata[127:64]);
            if (m_axis_tvalid && m_axis_tready)
                ledger.check_result(m_axis_tdata, m_axis_tuser[0]);
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: changing stall patterns plus one long hold-off
    // ------------------------------------------------------------------------
    initial
    begin
        int  seg_left;
        int  style;
        bit  hold_done;
        seg_left  = 0;
        style     = 0;
        hold_done = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    style    = $urandom_range(0, 2);
                    seg_left = $urandom_range(20, 120);
                end
                seg_left--;
                case (style)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Offer one request and hold it until it is taken
    task automatic send_div(logic [MODE_W-1:0] mode, logic [63:0] a, logic [63:0] b);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= mode;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Drop valid for a number of cycles
    task automatic idle_input(int cycles);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= {$urandom, $urandom, $urandom, $urandom};
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Operand of mixed magnitude: full width, shifted, special, small, near a power of two or negated
    function automatic logic [63:0] pick_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0, 1, 2: ;
            3:       v = v >> $urandom_range(0, 63);
            4:
            begin
                case ($urandom_range(0, 4))
                    0:       v = '0;
                    1:       v = 64'd1;
                    2:       v = ALL_ONES;
                    3:       v = MOST_NEG;
                    default: v = MOST_POS;
                endcase
            end
            5:       v = 64'($urandom_range(0, 15));
            6:       v = (64'd1 << $urandom_range(0, 63)) + 64'($urandom_range(0, 2)) - 64'd1;
            default: v = -(v >> $urandom_range(0, 63));
        endcase
        return v;
    endfunction

    task automatic send_random();
        logic [63:0] b;
        b = ($urandom_range(0, 39) == 0) ? '0 : pick_operand();
        send_div(MODE_W'($urandom_range(0, 3)), pick_operand(), b);
    endtask

    initial
    begin
        int sent;
        int burst;

        // Reset
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed corners: zero divisor, overflow, sign mixes, carry path
        send_div(idm_pkg::MODE_UQUOT, '0, '0);
        send_div(idm_pkg::MODE_UREM, ALL_ONES, '0);
        send_div(idm_pkg::MODE_SQUOT, -64'd7, '0);
        send_div(idm_pkg::MODE_SREM, -64'd7, '0);
        send_div(idm_pkg::MODE_SQUOT, 64'd100, '0);
        send_div(idm_pkg::MODE_SQUOT, MOST_NEG, ALL_ONES);
        send_div(idm_pkg::MODE_SREM, MOST_NEG, ALL_ONES);
        send_div(idm_pkg::MODE_UQUOT, ALL_ONES, 64'd1);
        send_div(idm_pkg::MODE_UREM, ALL_ONES, ALL_ONES);
        send_div(idm_pkg::MODE_UQUOT, 64'd1, ALL_ONES);
        send_div(idm_pkg::MODE_SQUOT, 64'd7, -64'd2);
        send_div(idm_pkg::MODE_SREM, -64'd7, 64'd2);
        send_div(idm_pkg::MODE_SQUOT, -64'd7, -64'd2);
        send_div(idm_pkg::MODE_SREM, 64'd7, -64'd2);
        send_div(idm_pkg::MODE_UQUOT, MOST_NEG, 64'd3);
        send_div(idm_pkg::MODE_UREM, ALL_ONES, 64'd10);
        send_div(idm_pkg::MODE_SQUOT, MOST_POS, 64'd1);
        send_div(idm_pkg::MODE_SREM, MOST_NEG, MOST_POS);
        send_div(idm_pkg::MODE_UQUOT, 64'd12345, MOST_NEG);
        send_div(idm_pkg::MODE_UREM, ALL_ONES, MOST_NEG + 64'd1);
        send_div(idm_pkg::MODE_SQUOT, MOST_NEG, 64'd2);
        send_div(idm_pkg::MODE_SREM, MOST_POS, MOST_NEG);

        // Pause until the chain has drained
        idle_input(1);
        while (ledger.outstanding() != 0) @(posedge clk);

        // Back-to-back requests against a long receiver hold-off
        hold_off_req = 1'b1;
        for (sent = 0; sent < FILL_ITEMS; sent++)
            send_random();

        // Random bursts with random gaps
        while (sent < RAND_ITEMS)
        begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst && sent < RAND_ITEMS; i++)
            begin
                send_random();
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                idle_input($urandom_range(1, 12));
        end

        // Drain and report
        idle_input(1);
        while (ledger.outstanding() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (ledger.failures == 0 && ledger.outstanding() == 0)
            $display("int64_divide_modulo: match");
        else
            $display("int64_divide_modulo: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/idm_pkg.sv
rtl/core/idm_prep_cell.sv
rtl/core/idm_div_cell.sv
rtl/core/idm_finish_cell.sv
rtl/core/int64_divide_modulo.sv
test/tb_top.sv
